// File: design/bdac_pkg.sv
// bdac_pkg: shared constants, codes and types of the byte-chunk DAC store.
// No dependencies.
package bdac_pkg;

    localparam int LEVELS_DEF  = 4;
    localparam int ENTRIES_DEF = 4096;

    localparam int VAL_W  = 32;
    localparam int IDX_W  = 12;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 3;   // byte count of a 32-bit value, 1..4
    localparam int LVL_W  = 3;   // wide enough for any level index up to seven

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_LEAF   = 2'd1;
    localparam logic [OP_W-1:0] OP_ACCESS = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_UNWRITTEN = 2'd2;

    typedef struct packed {
        logic             inc;    // bump fill count of lvl
        logic [LVL_W-1:0] lvl;    // level selected for read and bump
        logic             raise;  // load new top level
        logic [LVL_W-1:0] top;
    } t_fill_cmd;

endpackage

// File: design/bdac_ram.sv
// bdac_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bdac_fill.sv
// bdac_fill: per-level fill counters, top level register and full flags.
// Depends on bdac_pkg (t_fill_cmd).
module bdac_fill #(
    parameter int LEVELS  = bdac_pkg::LEVELS_DEF,
    parameter int ENTRIES = bdac_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bdac_pkg::t_fill_cmd          i_cmd,
    output logic [$clog2(ENTRIES+1)-1:0] o_fill_sel,
    output logic [$clog2(ENTRIES+1)-1:0] o_fill0,
    output logic [LEVELS-1:0]            o_full,
    output logic [$clog2(LEVELS)-1:0]    o_top
);

    localparam int LW = $clog2(LEVELS);
    localparam int FW = $clog2(ENTRIES + 1);

    logic [FW-1:0] r_fill [LEVELS];
    logic [LW-1:0] r_top;
    logic [LW-1:0] sel;

    assign sel = i_cmd.lvl[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_fill[l] <= '0;
            end
            r_top <= '0;
        end else begin
            if (i_cmd.inc) begin
                r_fill[sel] <= r_fill[sel] + 1'b1;
            end
            if (i_cmd.raise) begin
                r_top <= i_cmd.top[LW-1:0];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            o_full[l] = (r_fill[l] >= FW'(ENTRIES));
        end
    end

    assign o_fill_sel = r_fill[sel];
    assign o_fill0    = r_fill[0];
    assign o_top      = r_top;

endmodule

// File: design/byte_level_dac_store.sv
// byte_level_dac_store: top level, sequencer over the chunk RAM and fill unit.
// Depends on bdac_pkg, bdac_ram, bdac_fill.
//
// Usage:
//   An operation is transferred at a clock edge with start high and busy low.
//   i_operation selects append value, append leaf low byte or access entry;
//   i_value carries the value to append and i_index the level-0 entry to read.
//   Exactly one result follows per operation, shown for one cycle with
//   o_valid high on o_result_value, o_position and o_status; the receiver
//   takes it at the end of that cycle and cannot stall it.
//   Steps from the transfer to the result strobe:
//     rejected append, bad index, unused operation: the check state only
//     append of N bytes (leaf: N = 1): check, then one RAM write per level
//     access following L levels: check, then one RAM read per level
//   busy is high from the transfer to the result; a new operation may be
//   transferred in the cycle its predecessor's result is shown. The single
//   port pair of the chunk RAM sets the one-level-per-cycle pace.
//   Reset clears the fill counters and the top level; the chunk RAM is not
//   cleared and no entry reads back before it is written.
module byte_level_dac_store #(
    parameter int LEVELS  = bdac_pkg::LEVELS_DEF,
    parameter int ENTRIES = bdac_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bdac_pkg::OP_W-1:0]   i_operation,
    input  logic [bdac_pkg::VAL_W-1:0]  i_value,
    input  logic [bdac_pkg::IDX_W-1:0]  i_index,
    output logic                        o_valid,
    output logic [bdac_pkg::VAL_W-1:0]  o_result_value,
    output logic [bdac_pkg::IDX_W-1:0]  o_position,
    output logic [bdac_pkg::ST_W-1:0]   o_status
);

    localparam int LW    = $clog2(LEVELS);
    localparam int PW    = $clog2(ENTRIES);
    localparam int FW    = $clog2(ENTRIES + 1);
    localparam int AW    = LW + PW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = bdac_pkg::BYTE_W + 1 + PW;
    localparam int BW    = bdac_pkg::BYTE_W;
    localparam int CW    = bdac_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_WRITE = 4'b0100,
        S_READ  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [bdac_pkg::OP_W-1:0]  r_op;
    logic [bdac_pkg::VAL_W-1:0] r_value;
    logic [bdac_pkg::IDX_W-1:0] r_index;
    logic [CW-1:0]              r_count;
    logic [LW-1:0]              r_lvl, n_lvl;
    logic [PW-1:0]              r_child, n_child;
    logic [bdac_pkg::VAL_W-1:0] r_acc, n_acc;

    logic                       r_valid, n_valid;
    logic [bdac_pkg::VAL_W-1:0] r_res_value, n_res_value;
    logic [bdac_pkg::IDX_W-1:0] r_res_pos, n_res_pos;
    logic [bdac_pkg::ST_W-1:0]  r_res_status, n_res_status;

    logic                       accept;
    logic [CW-1:0]              in_count;

    bdac_pkg::t_fill_cmd        fill_cmd;
    logic [FW-1:0]              fill_sel;
    logic [FW-1:0]              fill0;
    logic [LEVELS-1:0]          full;
    logic [LW-1:0]              top;

    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [DW-1:0]              ram_wdata, ram_rdata;

    logic [LEVELS-1:0]          need_mask;
    logic                       too_many, lvl_full, idx_bad;
    logic [1:0]                 lane;
    logic                       wr_flag;
    logic [BW-1:0]              rd_byte;
    logic                       rd_flag;
    logic [PW-1:0]              rd_child;
    logic                       rd_more;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        if (i_value[31:24] != '0) begin
            in_count = CW'(4);
        end else if (i_value[23:16] != '0) begin
            in_count = CW'(3);
        end else if (i_value[15:8] != '0) begin
            in_count = CW'(2);
        end else begin
            in_count = CW'(1);
        end
    end

    bdac_fill #(
        .LEVELS  (LEVELS),
        .ENTRIES (ENTRIES)
    ) u_fill (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (fill_cmd),
        .o_fill_sel (fill_sel),
        .o_fill0    (fill0),
        .o_full     (full),
        .o_top      (top)
    );

    bdac_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_chunks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            need_mask[l] = (l < int'(r_count));
        end
    end

    assign too_many = (int'(r_count) > LEVELS);
    assign lvl_full = |(full & need_mask);
    assign idx_bad  = (32'(r_index) >= 32'(fill0)) || (32'(r_index) >= 32'(ENTRIES));
    assign lane     = 2'(r_lvl);
    assign wr_flag  = (r_lvl != LW'(r_count - 1'b1));
    assign rd_byte  = ram_rdata[BW-1:0];
    assign rd_child = ram_rdata[BW +: PW];
    assign rd_flag  = ram_rdata[DW-1];
    assign rd_more  = rd_flag && (r_lvl < top) && ((32'(r_lvl) + 1) < LEVELS);

    always_comb begin
        n_state      = r_state;
        n_lvl        = r_lvl;
        n_child      = r_child;
        n_acc        = r_acc;
        n_valid      = 1'b0;
        n_res_value  = r_res_value;
        n_res_pos    = r_res_pos;
        n_res_status = r_res_status;
        fill_cmd     = '0;
        fill_cmd.lvl = bdac_pkg::LVL_W'(r_lvl);
        ram_we       = 1'b0;
        ram_waddr    = {r_lvl, PW'(fill_sel)};
        ram_wdata    = {wr_flag, (wr_flag ? r_child : PW'(0)),
                        r_value[{lane, 3'b000} +: BW]};
        ram_re       = 1'b0;
        ram_raddr    = {LW'(0), PW'(r_index)};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                case (r_op)
                    bdac_pkg::OP_APPEND, bdac_pkg::OP_LEAF: begin
                        if (too_many || lvl_full) begin
                            n_valid      = 1'b1;
                            n_res_value  = '0;
                            n_res_pos    = '0;
                            n_res_status = bdac_pkg::ST_FULL;
                            n_state      = S_IDLE;
                        end else begin
                            n_lvl   = LW'(r_count - 1'b1);
                            n_state = S_WRITE;
                            if ((r_count - 1'b1) > CW'(top)) begin
                                fill_cmd.raise = 1'b1;
                                fill_cmd.top   = bdac_pkg::LVL_W'(r_count - 1'b1);
                            end
                        end
                    end
                    bdac_pkg::OP_ACCESS: begin
                        if (idx_bad) begin
                            n_valid      = 1'b1;
                            n_res_value  = '0;
                            n_res_pos    = '0;
                            n_res_status = bdac_pkg::ST_UNWRITTEN;
                            n_state      = S_IDLE;
                        end else begin
                            ram_re  = 1'b1;
                            n_lvl   = '0;
                            n_acc   = '0;
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        n_valid      = 1'b1;
                        n_res_value  = '0;
                        n_res_pos    = '0;
                        n_res_status = bdac_pkg::ST_OK;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_WRITE: begin
                // top-down: child of this level is the slot just used above
                ram_we       = 1'b1;
                fill_cmd.inc = 1'b1;
                n_child      = PW'(fill_sel);
                if (r_lvl == '0) begin
                    n_valid      = 1'b1;
                    n_res_value  = '0;
                    n_res_pos    = bdac_pkg::IDX_W'(fill_sel);
                    n_res_status = bdac_pkg::ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    n_lvl = r_lvl - 1'b1;
                end
            end
            S_READ: begin
                if (32'(r_lvl) < 4) begin
                    n_acc = r_acc | (32'(rd_byte) << {lane, 3'b000});
                end
                if (rd_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = {r_lvl + 1'b1, rd_child};
                    n_lvl     = r_lvl + 1'b1;
                end else begin
                    n_valid      = 1'b1;
                    n_res_value  = n_acc;
                    n_res_pos    = '0;
                    n_res_status = bdac_pkg::ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_value <= i_value;
            r_index <= i_index;
            r_count <= (i_operation == bdac_pkg::OP_LEAF) ? CW'(1) : in_count;
        end
        r_lvl        <= n_lvl;
        r_child      <= n_child;
        r_acc        <= n_acc;
        r_res_value  <= n_res_value;
        r_res_pos    <= n_res_pos;
        r_res_status <= n_res_status;
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_res_value;
    assign o_position     = r_res_pos;
    assign o_status       = r_res_status;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after transfer");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bdac_pkg::ST_OK) |->
            (o_result_value == '0 && o_position == '0))
        else $error("rejected result carries data");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_valid |=> !busy)
        else $error("result given while still busy");

endmodule
